>>> sv/arp_request_responder_assert.svh
// Assertion helpers used by the responder top level.
// Both sample on aclk and stay quiet while aresetn is low.
`ifndef ARP_REQUEST_RESPONDER_ASSERT_SVH
`define ARP_REQUEST_RESPONDER_ASSERT_SVH

// Same-cycle implication.
`define ARPR_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ARPR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/arpr_pkg.sv
`default_nettype none
package arpr_pkg;

    // Frame length and byte position width; covers store depths up to 127 bytes.
    localparam int LEN_W = 7;

    localparam int MIN_FRAME = 42;

    // Byte offsets in the frame.
    localparam int OFS_ETH_SRC  = 6;
    localparam int OFS_ETH_TYPE = 12;
    localparam int OFS_PTYPE    = 16;
    localparam int OFS_OPER     = 20;
    localparam int OFS_SHA      = 22;
    localparam int OFS_SPA      = 28;
    localparam int OFS_THA      = 32;
    localparam int OFS_TPA      = 38;

    localparam logic [15:0] ETH_TYPE_ARP = 16'h0806;
    localparam logic [15:0] PTYPE_IPV4   = 16'h0800;
    localparam logic [15:0] OPER_REQUEST = 16'h0001;
    localparam logic [15:0] OPER_REPLY   = 16'h0002;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } arpr_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } arpr_out_t;

    // Handoff from the receive side to the reply side.
    typedef struct packed {
        logic             start;
        logic [LEN_W-1:0] len;
    } arpr_start_t;

endpackage
`default_nettype wire

>>> sv/arp_request_responder.sv
// ARP request responder. Frame bytes enter on s_ one item per cycle while
// s_ready is high; those that fit are written into a MAX_FRAME-byte frame
// memory. At the last byte the Ethernet type, ARP protocol type and opcode
// (captured as they pass) and the length (42 to MAX_FRAME bytes) decide
// whether to answer. A valid request produces a reply of the same length on
// m_, one byte per cycle while m_ready stays high. During the reply s_ready
// is low, since new bytes would overwrite the stored request that the frame
// memory's read port is streaming; it rises again once the final reply byte
// sits in the output register. Rejected frames produce nothing and the next
// frame may follow at once. own_mac is written through cfg_ and must only
// change while the block is idle.
`default_nettype none
module arp_request_responder
    import arpr_pkg::*;
#(
    parameter int MAX_FRAME = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire arpr_in_t    s_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output arpr_out_t        m_data,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [47:0] cfg_data
);

    `include "arp_request_responder_assert.svh"

    localparam int AW = $clog2(MAX_FRAME);

    logic [47:0]   own_mac_reg;
    logic          tx_busy;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;
    arpr_start_t   start;

    // Take register writes at any time; callers keep them to idle periods.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_mac_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            own_mac_reg <= cfg_data;
        end
    end

    // Store incoming bytes and check the header.
    arpr_rx_ctrl #(
        .MAX_FRAME (MAX_FRAME),
        .AW        (AW)
    ) u_rx (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .tx_busy   (tx_busy),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .start     (start)
    );

    // Frame memory: one write port for receive, one read port for reply.
    arpr_frame_ram #(
        .DEPTH (MAX_FRAME),
        .AW    (AW)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Read back the request and build the reply stream.
    arpr_tx_ctrl #(
        .AW (AW)
    ) u_tx (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (start),
        .own_mac   (own_mac_reg),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .busy      (tx_busy),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // A reply may only start while the read side is free.
    `ARPR_ASSERT_SAME(a_start_idle, start.start, !tx_busy, "reply started while busy")
    // Accepted replies always cover a legal frame length.
    `ARPR_ASSERT_SAME(a_start_len, start.start,
        start.len >= LEN_W'(MIN_FRAME) && start.len <= LEN_W'(MAX_FRAME),
        "reply length out of range")
    // Never overwrite the stored request while it is being read back.
    `ARPR_ASSERT_SAME(a_wr_idle, ram_we, !tx_busy, "frame memory written during reply")
    // Hold a stalled reply item until it is taken.
    `ARPR_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data),
        "reply item changed while stalled")

endmodule
`default_nettype wire

>>> sv/arpr_frame_ram.sv
`default_nettype none
module arpr_frame_ram
    import arpr_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire logic          aclk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [7:0]    wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr,
    output logic      [7:0]    rdata
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Hold read data while no read is issued.
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

>>> sv/arpr_rx_ctrl.sv
`default_nettype none
module arpr_rx_ctrl
    import arpr_pkg::*;
#(
    parameter int MAX_FRAME = 64,
    parameter int AW        = 6
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire arpr_in_t      s_data,
    input  wire logic          tx_busy,
    output logic               ram_we,
    output logic      [AW-1:0] ram_waddr,
    output logic      [7:0]    ram_wdata,
    output arpr_start_t        start
);

    logic [LEN_W-1:0] count_reg, count_next;
    logic             ovf_reg, ovf_next;
    logic [7:0]       type_hi_reg, type_lo_reg;
    logic [7:0]       ptype_hi_reg, ptype_lo_reg;
    logic [7:0]       oper_hi_reg, oper_lo_reg;
    logic             accept;
    logic             fits;
    logic [LEN_W-1:0] len;
    logic             hdr_ok;

    assign s_ready   = !tx_busy;
    assign accept    = s_valid && s_ready;
    assign fits      = count_reg < LEN_W'(MAX_FRAME);
    assign len       = count_reg + LEN_W'(1);
    assign ram_we    = accept && fits;
    assign ram_waddr = count_reg[AW-1:0];
    assign ram_wdata = s_data.in_byte;

    assign hdr_ok = ({type_hi_reg, type_lo_reg} == ETH_TYPE_ARP)
                 && ({ptype_hi_reg, ptype_lo_reg} == PTYPE_IPV4)
                 && ({oper_hi_reg, oper_lo_reg} == OPER_REQUEST);

    always_comb begin
        count_next  = count_reg;
        ovf_next    = ovf_reg;
        start.start = 1'b0;
        start.len   = len;
        if (accept) begin
            if (fits) begin
                count_next = len;
            end else begin
                ovf_next = 1'b1;
            end
            if (s_data.in_last) begin
                count_next  = '0;
                ovf_next    = 1'b0;
                start.start = !ovf_reg && fits && (len >= LEN_W'(MIN_FRAME)) && hdr_ok;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end else begin
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

    // Capture the header fields that decide whether to answer.
    always_ff @(posedge aclk) begin
        if (accept) begin
            if (count_reg == LEN_W'(OFS_ETH_TYPE))     type_hi_reg  <= s_data.in_byte;
            if (count_reg == LEN_W'(OFS_ETH_TYPE + 1)) type_lo_reg  <= s_data.in_byte;
            if (count_reg == LEN_W'(OFS_PTYPE))        ptype_hi_reg <= s_data.in_byte;
            if (count_reg == LEN_W'(OFS_PTYPE + 1))    ptype_lo_reg <= s_data.in_byte;
            if (count_reg == LEN_W'(OFS_OPER))         oper_hi_reg  <= s_data.in_byte;
            if (count_reg == LEN_W'(OFS_OPER + 1))     oper_lo_reg  <= s_data.in_byte;
        end
    end

endmodule
`default_nettype wire

>>> sv/arpr_tx_ctrl.sv
`default_nettype none
module arpr_tx_ctrl
    import arpr_pkg::*;
#(
    parameter int AW = 6
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire arpr_start_t   start,
    input  wire logic [47:0]   own_mac,
    output logic               ram_re,
    output logic      [AW-1:0] ram_raddr,
    input  wire logic [7:0]    ram_rdata,
    output logic               busy,
    output logic               m_valid,
    input  wire logic          m_ready,
    output arpr_out_t          m_data
);

    logic [LEN_W-1:0] issue_idx_reg;
    logic [LEN_W-1:0] len_reg;
    logic             issuing_reg;
    logic             s1_vld_reg;
    logic [LEN_W-1:0] s1_idx_reg;
    logic             s1_last_reg;
    logic             m_valid_reg;
    arpr_out_t        m_data_reg;
    logic             advance;
    logic             issue_last;
    logic [LEN_W-1:0] src_idx;
    logic [LEN_W-1:0] mac_k;
    logic [47:0]      mac_sh;
    logic [7:0]       out_byte_next;

    assign advance    = !m_valid_reg || m_ready;
    assign issue_last = (issue_idx_reg + LEN_W'(1)) == len_reg;
    assign busy       = issuing_reg || s1_vld_reg;
    assign m_valid    = m_valid_reg;
    assign m_data     = m_data_reg;

    // Map reply position to the request byte it echoes.
    always_comb begin
        if (issue_idx_reg < LEN_W'(OFS_ETH_SRC)) begin
            src_idx = issue_idx_reg + LEN_W'(OFS_SHA);
        end else if (issue_idx_reg >= LEN_W'(OFS_SPA) && issue_idx_reg < LEN_W'(OFS_THA)) begin
            src_idx = issue_idx_reg + LEN_W'(OFS_TPA - OFS_SPA);
        end else if (issue_idx_reg >= LEN_W'(OFS_THA)
                     && issue_idx_reg < LEN_W'(MIN_FRAME)) begin
            src_idx = issue_idx_reg - LEN_W'(OFS_THA - OFS_SHA);
        end else begin
            src_idx = issue_idx_reg;
        end
    end

    assign ram_re    = advance && issuing_reg;
    assign ram_raddr = src_idx[AW-1:0];

    // Substitute own address and reply opcode over the echoed byte.
    always_comb begin
        if (s1_idx_reg >= LEN_W'(OFS_SHA)) begin
            mac_k = s1_idx_reg - LEN_W'(OFS_SHA);
        end else begin
            mac_k = s1_idx_reg - LEN_W'(OFS_ETH_SRC);
        end
        mac_sh = own_mac >> {3'd5 - mac_k[2:0], 3'b000};
        if ((s1_idx_reg >= LEN_W'(OFS_ETH_SRC) && s1_idx_reg < LEN_W'(OFS_ETH_TYPE))
            || (s1_idx_reg >= LEN_W'(OFS_SHA) && s1_idx_reg < LEN_W'(OFS_SPA))) begin
            out_byte_next = mac_sh[7:0];
        end else if (s1_idx_reg == LEN_W'(OFS_OPER)) begin
            out_byte_next = OPER_REPLY[15:8];
        end else if (s1_idx_reg == LEN_W'(OFS_OPER + 1)) begin
            out_byte_next = OPER_REPLY[7:0];
        end else begin
            out_byte_next = ram_rdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            issuing_reg <= 1'b0;
            s1_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (advance) begin
                m_valid_reg <= s1_vld_reg;
                s1_vld_reg  <= issuing_reg;
                if (issuing_reg && issue_last) begin
                    issuing_reg <= 1'b0;
                end
            end
            if (start.start) begin
                issuing_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            if (s1_vld_reg) begin
                m_data_reg.out_byte <= out_byte_next;
                m_data_reg.out_last <= s1_last_reg;
            end
            s1_idx_reg  <= issue_idx_reg;
            s1_last_reg <= issue_last;
            if (issuing_reg) begin
                issue_idx_reg <= issue_idx_reg + LEN_W'(1);
            end
        end
        if (start.start) begin
            issue_idx_reg <= '0;
            len_reg       <= start.len;
        end
    end

endmodule
`default_nettype wire
